### design/sqe_pkg.sv
// sqe_pkg: shared types and codes for the stack/queue engine.
// No dependencies; imported by every module of the block.
package sqe_pkg;

    // operation carried by one input word
    typedef enum logic [2:0] {
        MODE_PUSH = 3'd0,
        MODE_LIST = 3'd1,
        MODE_PEEK = 3'd2,
        MODE_POP  = 3'd3,
        MODE_SWAP = 3'd4
    } t_mode;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BADARG     = 3'd1,
        ST_PEEK_EMPTY = 3'd2,
        ST_POP_EMPTY  = 3'd3,
        ST_SWAP_SHORT = 3'd4,
        ST_FULL       = 3'd5,
        ST_HALTED     = 3'd6
    } t_status;

    localparam int unsigned DATA_W = 32;

    // one result word
    typedef struct packed {
        t_status                   status;
        logic                      has_value;
        logic signed [DATA_W-1:0]  value;
        logic                      last;
    } t_result;

endpackage

### design/sqe_mem.sv
// sqe_mem: value store, one write port and one registered read port.
// Depends on sqe_pkg for the data width.
module sqe_mem #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [AW-1:0]                       i_waddr,
    input  logic signed [sqe_pkg::DATA_W-1:0]   i_wdata,
    input  logic [AW-1:0]                       i_raddr,
    output logic signed [sqe_pkg::DATA_W-1:0]   o_rdata
);
    import sqe_pkg::*;

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/sqe_ctrl.sv
// sqe_ctrl: sequencer for the engine: pointers, count, halt flag,
// read-modify-write of the store and the registered result word.
// Depends on sqe_pkg; drives the ports of sqe_mem.
module sqe_ctrl #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_queue_mode,
    input  logic                                i_start,
    input  logic [2:0]                          i_mode,
    input  logic signed [sqe_pkg::DATA_W-1:0]   i_push_value,
    input  logic                                i_value_ok,
    output logic                                o_busy,
    output logic                                o_strobe,
    output sqe_pkg::t_result                    o_res,
    output logic                                o_mem_we,
    output logic [AW-1:0]                       o_mem_waddr,
    output logic signed [sqe_pkg::DATA_W-1:0]   o_mem_wdata,
    output logic [AW-1:0]                       o_mem_raddr,
    input  logic signed [sqe_pkg::DATA_W-1:0]   i_mem_rdata
);
    import sqe_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = AW + 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PEEK = 6'b000010,
        S_LIST = 6'b000100,
        S_SW1  = 6'b001000,
        S_SW2  = 6'b010000,
        S_SW3  = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [AW-1:0]    r_top, n_top;
    logic [CW-1:0]    r_count, n_count;
    logic             r_halted, n_halted;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [AW-1:0]    r_idx, n_idx;
    logic signed [DATA_W-1:0] r_tmp, n_tmp;
    logic             r_strobe, n_strobe;
    t_result          r_res, n_res;

    logic             accept;
    logic [SW-1:0]    tail_sum;
    logic [AW-1:0]    tail_slot;
    logic             list_last;

    // ring step toward the bottom
    function automatic logic [AW-1:0] fwd1(input logic [AW-1:0] p);
        fwd1 = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    // ring step toward the top
    function automatic logic [AW-1:0] back1(input logic [AW-1:0] p);
        back1 = (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

    function automatic t_result mk_res(input t_status st, input logic hv,
                                       input logic signed [DATA_W-1:0] v,
                                       input logic l);
        mk_res.status    = st;
        mk_res.has_value = hv;
        mk_res.value     = v;
        mk_res.last      = l;
    endfunction

    assign o_busy  = (r_state != S_IDLE);
    assign accept  = i_start && !o_busy;

    // slot under the bottom entry for a queue push; count < DEPTH here
    assign tail_sum  = SW'(r_top) + SW'(r_count);
    assign tail_slot = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH))
                                                : AW'(tail_sum);

    assign list_last = ((CW'(r_idx) + CW'(1)) == r_count);

    // next-state and store access
    always_comb begin
        n_state     = r_state;
        n_top       = r_top;
        n_count     = r_count;
        n_halted    = r_halted;
        n_rd_ptr    = r_rd_ptr;
        n_idx       = r_idx;
        n_tmp       = r_tmp;
        n_strobe    = 1'b0;
        n_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_top;
        o_mem_wdata = i_push_value;
        o_mem_raddr = r_top;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_halted) begin
                        n_strobe = 1'b1;
                        n_res    = mk_res(ST_HALTED, 1'b0, '0, 1'b1);
                    end else begin
                        case (t_mode'(i_mode))
                            MODE_PUSH: begin
                                n_strobe = 1'b1;
                                if (!i_value_ok) begin
                                    n_halted = 1'b1;
                                    n_res    = mk_res(ST_BADARG, 1'b0, '0, 1'b1);
                                end else if (r_count == CW'(DEPTH)) begin
                                    n_halted = 1'b1;
                                    n_res    = mk_res(ST_FULL, 1'b0, '0, 1'b1);
                                end else begin
                                    o_mem_we = 1'b1;
                                    if (i_queue_mode) begin
                                        o_mem_waddr = tail_slot;
                                    end else begin
                                        o_mem_waddr = back1(r_top);
                                        n_top       = back1(r_top);
                                    end
                                    n_count = r_count + CW'(1);
                                    n_res   = mk_res(ST_OK, 1'b0, '0, 1'b1);
                                end
                            end
                            MODE_LIST: begin
                                if (r_count == '0) begin
                                    n_strobe = 1'b1;
                                    n_res    = mk_res(ST_OK, 1'b0, '0, 1'b1);
                                end else begin
                                    n_rd_ptr = r_top;
                                    n_idx    = '0;
                                    n_state  = S_LIST;
                                end
                            end
                            MODE_PEEK: begin
                                if (r_count == '0) begin
                                    n_strobe = 1'b1;
                                    n_halted = 1'b1;
                                    n_res    = mk_res(ST_PEEK_EMPTY, 1'b0, '0, 1'b1);
                                end else begin
                                    n_state = S_PEEK;
                                end
                            end
                            MODE_POP: begin
                                n_strobe = 1'b1;
                                if (r_count == '0) begin
                                    n_halted = 1'b1;
                                    n_res    = mk_res(ST_POP_EMPTY, 1'b0, '0, 1'b1);
                                end else begin
                                    n_top   = fwd1(r_top);
                                    n_count = r_count - CW'(1);
                                    n_res   = mk_res(ST_OK, 1'b0, '0, 1'b1);
                                end
                            end
                            MODE_SWAP: begin
                                if (r_count < CW'(2)) begin
                                    n_strobe = 1'b1;
                                    n_halted = 1'b1;
                                    n_res    = mk_res(ST_SWAP_SHORT, 1'b0, '0, 1'b1);
                                end else begin
                                    n_state = S_SW1;
                                end
                            end
                            default: begin
                                n_strobe = 1'b1;
                                n_res    = mk_res(ST_OK, 1'b0, '0, 1'b1);
                            end
                        endcase
                    end
                end
            end
            // top value arrives from the store
            S_PEEK: begin
                n_strobe = 1'b1;
                n_res    = mk_res(ST_OK, 1'b1, i_mem_rdata, 1'b1);
                n_state  = S_IDLE;
            end
            // one element per cycle, next read issued alongside
            S_LIST: begin
                n_strobe = 1'b1;
                n_res    = mk_res(ST_OK, 1'b1, i_mem_rdata, list_last);
                if (list_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_mem_raddr = fwd1(r_rd_ptr);
                    n_rd_ptr    = fwd1(r_rd_ptr);
                    n_idx       = r_idx + AW'(1);
                end
            end
            // hold the top word, fetch the one below
            S_SW1: begin
                n_tmp       = i_mem_rdata;
                o_mem_raddr = fwd1(r_top);
                n_state     = S_SW2;
            end
            S_SW2: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_top;
                o_mem_wdata = i_mem_rdata;
                n_state     = S_SW3;
            end
            S_SW3: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = fwd1(r_top);
                o_mem_wdata = r_tmp;
                n_strobe    = 1'b1;
                n_res       = mk_res(ST_OK, 1'b0, '0, 1'b1);
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_top    <= '0;
            r_count  <= '0;
            r_halted <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_top    <= n_top;
            r_count  <= n_count;
            r_halted <= n_halted;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_ptr <= n_rd_ptr;
        r_idx    <= n_idx;
        r_tmp    <= n_tmp;
        r_res    <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

### design/stack_queue_engine.sv
// stack_queue_engine: top level of the stack/queue engine.
// Depends on sqe_pkg, sqe_mem and sqe_ctrl.
//
// Usage:
//   Command channel: drive i_mode, i_push_value, i_value_ok with i_start;
//   the word is taken at a clock edge with i_start high and o_busy low.
//   Results come back one word per cycle, flagged by o_strobe for a single
//   cycle; the receiver cannot stall them. o_last marks the final word of
//   a command.
//   Config channel: i_cfg_queue_mode is written when i_cfg_valid is high;
//   o_cfg_ready is always high. Write only while the engine is idle.
//   Timing: push, pop, errors and halted replies show o_strobe in the cycle
//   after the command and o_busy stays low (one command per cycle).
//   Peek holds o_busy while the top word is read; swap holds o_busy while
//   it fetches the word below, writes the top and writes the one below;
//   list of N values holds o_busy while it streams N words. In each case
//   o_busy falls as the answer (for list, the last word) appears; the busy
//   spans come from the single read and single write port of the value store.
//   Reset (synchronous, active low) empties the store, clears the halt
//   flag and selects stack mode; store contents are not cleared.
module stack_queue_engine #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [2:0]          i_mode,
    input  logic signed [31:0]  i_push_value,
    input  logic                i_value_ok,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_queue_mode,
    output logic                o_strobe,
    output logic [2:0]          o_status,
    output logic                o_has_value,
    output logic signed [31:0]  o_out_value,
    output logic                o_last
);
    import sqe_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);

    logic                      r_queue_mode;
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [AW-1:0]             mem_raddr;
    logic signed [DATA_W-1:0]  mem_wdata;
    logic signed [DATA_W-1:0]  mem_rdata;
    t_result                   res;

    // queue mode register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_queue_mode <= i_cfg_queue_mode;
        end
    end

    sqe_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_queue_mode (r_queue_mode),
        .i_start      (i_start),
        .i_mode       (i_mode),
        .i_push_value (i_push_value),
        .i_value_ok   (i_value_ok),
        .o_busy       (o_busy),
        .o_strobe     (o_strobe),
        .o_res        (res),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata)
    );

    sqe_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // result word onto the ports
    assign o_status    = res.status;
    assign o_has_value = res.has_value;
    assign o_out_value = res.value;
    assign o_last      = res.last;

endmodule

### design/sqe_chk.sv
// sqe_chk: port-level checks for stack_queue_engine, plus its bind.
// Depends on sqe_pkg for the status codes.
module sqe_chk (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                o_busy,
    input  logic                o_strobe,
    input  logic [2:0]          o_status,
    input  logic                o_has_value,
    input  logic signed [31:0]  o_out_value,
    input  logic                o_last
);
    import sqe_pkg::*;

    // a word without a value carries zero
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_has_value) |-> (o_out_value == '0))
        else $error("result without value has nonzero data");

    // any non-ok status is a single, final, valueless word
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_OK) |-> (o_last && !o_has_value))
        else $error("error result not final or carries a value");

    // an accepted command either answers next cycle or holds the engine
    a_accept_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_strobe || o_busy))
        else $error("accepted command neither answered nor busy");

    // a listing in progress keeps new commands out
    a_list_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> o_busy)
        else $error("non-final result while engine is idle");

endmodule

bind stack_queue_engine sqe_chk u_chk (.*);
